[sv/cfc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and fixed-point constants for the field cell colorizer.
// No dependencies; every other file of the block imports this package.
package cfc_pkg;

  // Number of register stages from the input transfer through the output register.
  localparam int NumStages = 6;

  // Color mode codes held in the mode register.
  typedef enum logic [1:0] {
    MODE_WHITE = 2'd0,
    MODE_HUE   = 2'd1,
    MODE_VEL   = 2'd2,
    MODE_NONE  = 2'd3
  } color_mode_t;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_COLOR_MODE  = 2'd0,
    REG_SATURATION  = 2'd1,
    REG_VALUE_LEVEL = 2'd2,
    REG_HUE_ALPHA   = 2'd3
  } reg_index_t;

  // Sixty-degree sector of the hue circle.
  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } hue_sector_t;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    color_mode_t mode;
    logic [8:0]  sat;        // saturation clamped to 256
    logic [15:0] v255;       // clamped value level times 255
    logic [7:0]  hue_alpha;
  } cfg_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

  // Density at or above this saturates the white-mode alpha.
  localparam logic [23:0] ALPHA_SAT_DENS = 24'd25651;
  localparam logic [31:0] ALPHA_ROUND    = 32'd12800;
  // Reciprocals: floor(m/100) = (m*5243)>>19 for m < 25600,
  // floor(h/360) = (h*11651)>>22 for h < 65536,
  // floor(w/60) = (w*17477)>>20 for w < 16384.
  localparam logic [12:0] RECIP_100      = 13'd5243;
  localparam logic [13:0] RECIP_360      = 14'd11651;
  localparam logic [14:0] RECIP_60       = 15'd17477;
  localparam logic [29:0] HSV_ROUND      = 30'd1966080;
  localparam logic [13:0] D_FULL         = 14'd15360;
  localparam logic [8:0]  FULL_SCALE     = 9'd256;

  // Velocity to offset position: 10*v + 32768 clamped to [0, 65536].
  function automatic logic [16:0] vel_clamp(input logic signed [17:0] v);
    logic signed [22:0] xs;
    logic [16:0]        res;
    xs = 23'(v) * 23'sd10 + 23'sd32768;
    if (xs < 23'sd0) begin
      res = 17'd0;
    end else if (xs > 23'sd65536) begin
      res = 17'd65536;
    end else begin
      res = xs[16:0];
    end
    return res;
  endfunction

  // Offset position to an 8-bit channel with round half up.
  function automatic logic [7:0] vel_chan(input logic [16:0] x);
    logic [24:0] t;
    t = 25'(x) * 25'd255 + 25'd32768;
    return t[23:16];
  endfunction

endpackage

[sv/cfc_regs.sv]
`timescale 1ns / 1ps
// APB-style configuration registers of the colorizer and their clamped views.
// Depends on cfc_pkg.
module cfc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfc_pkg::cfg_t       cfg
);
  import cfc_pkg::*;

  logic [1:0] color_mode;
  logic [8:0] saturation;
  logic [8:0] value_level;
  logic [7:0] hue_alpha;
  logic       wr_en;
  reg_index_t idx;
  logic [8:0] v_clamped;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= 2'd0;
      saturation  <= FULL_SCALE;
      value_level <= FULL_SCALE;
      hue_alpha   <= 8'hFF;
    end else if (wr_en) begin
      case (idx)
        REG_COLOR_MODE:  color_mode  <= pwdata[1:0];
        REG_SATURATION:  saturation  <= pwdata[8:0];
        REG_VALUE_LEVEL: value_level <= pwdata[8:0];
        REG_HUE_ALPHA:   hue_alpha   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the stored values.
  always_comb begin
    case (idx)
      REG_COLOR_MODE:  prdata = 32'(color_mode);
      REG_SATURATION:  prdata = 32'(saturation);
      REG_VALUE_LEVEL: prdata = 32'(value_level);
      REG_HUE_ALPHA:   prdata = 32'(hue_alpha);
      default:         prdata = 32'd0;
    endcase
  end

  // Values above one act as one; value is pre-scaled by 255 for the lanes.
  assign v_clamped     = (value_level > FULL_SCALE) ? FULL_SCALE : value_level;
  assign cfg.mode      = color_mode_t'(color_mode);
  assign cfg.sat       = (saturation > FULL_SCALE) ? FULL_SCALE : saturation;
  assign cfg.v255      = 16'({v_clamped, 8'd0} - 17'(v_clamped));
  assign cfg.hue_alpha = hue_alpha;

endmodule

[sv/cfc_hsv_term.sv]
`timescale 1ns / 1ps
// One HSV channel term: round(255 * V * d / 3932160) over two register stages.
// Depends on cfc_pkg.
module cfc_hsv_term (
  input  logic        clk,
  input  logic        load_a,
  input  logic        load_b,
  input  logic [15:0] v255,
  input  logic [13:0] d,
  output logic [7:0]  ch
);
  import cfc_pkg::*;

  logic [29:0] prod;
  logic [13:0] w;
  logic [28:0] qprod;

  // First stage: scaled product, rounded and divided by 65536.
  assign prod = 30'(v255) * 30'(d) + HSV_ROUND;

  always_ff @(posedge clk) begin
    if (load_a) begin
      w <= prod[29:16];
    end
  end

  // Second stage: the remaining division by 60 through a reciprocal.
  assign qprod = 29'(w) * 29'(RECIP_60);

  always_ff @(posedge clk) begin
    if (load_b) begin
      ch <= qprod[27:20];
    end
  end

endmodule

[sv/cfc_ctrl.sv]
`timescale 1ns / 1ps
// Valid bits and ready chain of the colorizer pipeline; a stage loads when it
// is empty or the stage after it moves. Depends on cfc_pkg.
module cfc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfc_pkg::pipe_ctrl_t   ctrl
);
  import cfc_pkg::*;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;

  // Ready propagates backward; bubbles are filled.
  always_comb begin
    rdy[NumStages] = out_ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld[NumStages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy[NumStages-1:0] & vld_in) | (~rdy[NumStages-1:0] & vld);
    end
  end

  assign ctrl.load = rdy[NumStages-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = vld[NumStages-1];

  // A draining sink never holds off the source.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // An accepted transfer occupies the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transfer lost at first stage");

  // An empty pipeline always accepts.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> in_ready)
    else $error("empty pipeline not ready");

endmodule

[sv/field_cell_colorizer.sv]
`timescale 1ns / 1ps
// Field cell colorizer: maps one cell's density and velocity to an RGBA color.
// Input channel: density, vel_x, vel_y with in_valid / in_ready.
// Output channel: red, green, blue, alpha with out_valid / out_ready.
// The mode register picks white with density alpha, a hue taken from the
// density, a velocity map, or transparent black for the unused code;
// saturation, value level and hue alpha shape the hue mode. The user must
// write the registers over the APB-style port only while the block is idle;
// the block itself does not enforce it. pready is always high.
// Throughput is one item per cycle while out_ready is high: six register
// stages, each with its own valid bit, and the hue path's multipliers split
// across them. When the receiver stalls, the results hold in place and empty
// stages still fill, so a full pipeline holds six items before in_ready drops.
// Reset empties the pipeline and loads mode white, saturation and value
// level of one, and an opaque hue alpha. Depends on cfc_pkg, cfc_regs,
// cfc_ctrl and cfc_hsv_term.
module field_cell_colorizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        density,
  input  logic signed [17:0] vel_x,
  input  logic signed [17:0] vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha
);
  import cfc_pkg::*;

  typedef struct packed {
    hue_sector_t sector;
    logic [7:0]  alpha0;
    logic [7:0]  vel_r;
    logic [7:0]  vel_g;
  } side_t;

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  cfc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cfc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctrl
  );

  // Stage 0: scaled density, hue quotient estimate, clamped velocities.
  logic [31:0] dens_n;
  logic [29:0] hq_prod;
  logic        s0_sat;
  logic [14:0] s0_m;
  logic [15:0] s0_h;
  logic [7:0]  s0_q;
  logic [16:0] s0_xr;
  logic [16:0] s0_xg;

  assign dens_n  = 32'(density) * 32'd255 + ALPHA_ROUND;
  assign hq_prod = 30'(density[23:8]) * 30'(RECIP_360);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s0_sat <= (density >= ALPHA_SAT_DENS);
      s0_m   <= dens_n[22:8];
      s0_h   <= density[23:8];
      s0_q   <= hq_prod[29:22];
      s0_xr  <= vel_clamp(vel_x);
      s0_xg  <= vel_clamp(vel_y);
    end
  end

  // Stage 1: white alpha, hue modulo 360, velocity channels.
  logic [27:0] a_prod;
  logic [16:0] h_mod;
  logic [7:0]  s1_alpha0;
  logic [8:0]  s1_hue;
  logic [7:0]  s1_vel_r;
  logic [7:0]  s1_vel_g;

  assign a_prod = 28'(s0_m) * 28'(RECIP_100);
  assign h_mod  = 17'(s0_h) - 17'(s0_q) * 17'd360;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s1_alpha0 <= s0_sat ? 8'hFF : a_prod[26:19];
      s1_hue    <= h_mod[8:0];
      s1_vel_r  <= vel_chan(s0_xr);
      s1_vel_g  <= vel_chan(s0_xg);
    end
  end

  // Stage 2: sector, fraction, and the differences 15360 - S*k.
  hue_sector_t sector;
  logic [8:0]  hue_rem;
  logic [5:0]  frac;
  logic [5:0]  frac_inv;
  logic [14:0] sp_p;
  logic [14:0] sp_q;
  logic [14:0] sp_t;
  logic [14:0] d_p_full;
  logic [14:0] d_q_full;
  logic [14:0] d_t_full;
  logic [13:0] s2_d_p;
  logic [13:0] s2_d_q;
  logic [13:0] s2_d_t;
  side_t       s2_side;
  side_t       s3_side;
  side_t       s4_side;

  always_comb begin
    if (s1_hue >= 9'd300) begin
      sector = SECTOR_5;
    end else if (s1_hue >= 9'd240) begin
      sector = SECTOR_4;
    end else if (s1_hue >= 9'd180) begin
      sector = SECTOR_3;
    end else if (s1_hue >= 9'd120) begin
      sector = SECTOR_2;
    end else if (s1_hue >= 9'd60) begin
      sector = SECTOR_1;
    end else begin
      sector = SECTOR_0;
    end
  end

  assign hue_rem  = s1_hue - 9'(sector) * 9'd60;
  assign frac     = hue_rem[5:0];
  assign frac_inv = 6'd60 - frac;
  assign sp_p     = 15'(cfg.sat) * 15'd60;
  assign sp_q     = 15'(cfg.sat) * 15'(frac);
  assign sp_t     = 15'(cfg.sat) * 15'(frac_inv);
  assign d_p_full = 15'(D_FULL) - sp_p;
  assign d_q_full = 15'(D_FULL) - sp_q;
  assign d_t_full = 15'(D_FULL) - sp_t;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s2_d_p         <= d_p_full[13:0];
      s2_d_q         <= d_q_full[13:0];
      s2_d_t         <= d_t_full[13:0];
      s2_side.sector <= sector;
      s2_side.alpha0 <= s1_alpha0;
      s2_side.vel_r  <= s1_vel_r;
      s2_side.vel_g  <= s1_vel_g;
    end
  end

  // Stages 3 and 4: the four channel terms, side data carried alongside.
  logic [7:0] c_v;
  logic [7:0] c_p;
  logic [7:0] c_q;
  logic [7:0] c_t;

  cfc_hsv_term u_term_v (
    .clk, .load_a(ctrl.load[3]), .load_b(ctrl.load[4]), .v255(cfg.v255),
    .d(D_FULL), .ch(c_v)
  );
  cfc_hsv_term u_term_p (
    .clk, .load_a(ctrl.load[3]), .load_b(ctrl.load[4]), .v255(cfg.v255),
    .d(s2_d_p), .ch(c_p)
  );
  cfc_hsv_term u_term_q (
    .clk, .load_a(ctrl.load[3]), .load_b(ctrl.load[4]), .v255(cfg.v255),
    .d(s2_d_q), .ch(c_q)
  );
  cfc_hsv_term u_term_t (
    .clk, .load_a(ctrl.load[3]), .load_b(ctrl.load[4]), .v255(cfg.v255),
    .d(s2_d_t), .ch(c_t)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s3_side <= s2_side;
    end
    if (ctrl.load[4]) begin
      s4_side <= s3_side;
    end
  end

  // Stage 5: sector assignment and mode selection into the output register.
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] alpha_next;
  logic [7:0] hr;
  logic [7:0] hg;
  logic [7:0] hb;

  always_comb begin
    case (s4_side.sector)
      SECTOR_1: begin hr = c_q; hg = c_v; hb = c_p; end
      SECTOR_2: begin hr = c_p; hg = c_v; hb = c_t; end
      SECTOR_3: begin hr = c_p; hg = c_q; hb = c_v; end
      SECTOR_4: begin hr = c_t; hg = c_p; hb = c_v; end
      SECTOR_5: begin hr = c_v; hg = c_p; hb = c_q; end
      default:  begin hr = c_v; hg = c_t; hb = c_p; end
    endcase
  end

  always_comb begin
    case (cfg.mode)
      MODE_WHITE: begin
        red_next   = 8'hFF;
        green_next = 8'hFF;
        blue_next  = 8'hFF;
        alpha_next = s4_side.alpha0;
      end
      MODE_HUE: begin
        red_next   = hr;
        green_next = hg;
        blue_next  = hb;
        alpha_next = cfg.hue_alpha;
      end
      MODE_VEL: begin
        red_next   = s4_side.vel_r;
        green_next = s4_side.vel_g;
        blue_next  = 8'hFF;
        alpha_next = 8'hFF;
      end
      default: begin
        red_next   = 8'd0;
        green_next = 8'd0;
        blue_next  = 8'd0;
        alpha_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
      alpha <= alpha_next;
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for field_cell_colorizer: random and directed cells
// through valid/ready, register writes over the APB-style port, and a scoreboard.
// Depends on cfc_pkg and the field_cell_colorizer RTL.
module testbench;
  import cfc_pkg::*;

  localparam int NUM_SEGMENTS      = 12;
  localparam int CELLS_PER_SEGMENT = 36;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Scoreboard: keeps its own copy of the registers, predicts the color of
  // every accepted cell and compares results in order.
  class color_scoreboard;
    rgba_t       pending_colors[$];
    int          errors;
    color_mode_t mode;
    logic [8:0]  sat_level;
    logic [8:0]  val_level;
    logic [7:0]  hue_opacity;

    function new();
      errors      = 0;
      mode        = MODE_WHITE;
      sat_level   = 9'd256;
      val_level   = 9'd256;
      hue_opacity = 8'd255;
    endfunction

    function void load_reg(reg_index_t idx, logic [31:0] data);
      case (idx)
        REG_COLOR_MODE:  mode = color_mode_t'(data[1:0]);
        REG_SATURATION:  sat_level = data[8:0];
        REG_VALUE_LEVEL: val_level = data[8:0];
        default:         hue_opacity = data[7:0];
      endcase
    endfunction

    // One HSV channel: round(255 * v * (15360 - s * k) / 3932160).
    function int unsigned hsv_level(int unsigned v, int unsigned s, int unsigned k);
      logic [63:0] num;
      num = 64'(v) * 64'd255 * 64'(15360 - s * k);
      return int'((num + 64'd1966080) / 64'd3932160);
    endfunction

    // Velocity clamped to +-0.05 and spread over 0..255.
    function logic [7:0] vel_level(logic signed [17:0] vel);
      longint x;
      x = 10 * longint'(vel) + 32768;
      if (x < 0) x = 0;
      if (x > 65536) x = 65536;
      return 8'((x * 255 + 32768) >> 16);
    endfunction

    function rgba_t colorize(logic [23:0] dens, logic signed [17:0] vx,
                             logic signed [17:0] vy);
      rgba_t         c;
      logic [63:0]   lvl;
      int unsigned   hue, rem, s, v, lv, lp, lq, lt;
      hue_sector_t   sector;
      c = '0;
      case (mode)
        MODE_WHITE: begin
          lvl = (64'(dens) * 64'd255 + 64'd12800) / 64'd25600;
          c = '{8'hFF, 8'hFF, 8'hFF, (lvl > 64'd255) ? 8'hFF : 8'(lvl)};
        end
        MODE_HUE: begin
          hue    = (int'(dens) >> 8) % 360;
          sector = hue_sector_t'(hue / 60);
          rem    = hue % 60;
          // Register values above one act as one.
          s  = (sat_level > 9'd256) ? 256 : int'(sat_level);
          v  = (val_level > 9'd256) ? 256 : int'(val_level);
          lv = hsv_level(v, s, 0);
          lp = hsv_level(v, s, 60);
          lq = hsv_level(v, s, rem);
          lt = hsv_level(v, s, 60 - rem);
          case (sector)
            SECTOR_1: c = '{8'(lq), 8'(lv), 8'(lp), hue_opacity};
            SECTOR_2: c = '{8'(lp), 8'(lv), 8'(lt), hue_opacity};
            SECTOR_3: c = '{8'(lp), 8'(lq), 8'(lv), hue_opacity};
            SECTOR_4: c = '{8'(lt), 8'(lp), 8'(lv), hue_opacity};
            SECTOR_5: c = '{8'(lv), 8'(lp), 8'(lq), hue_opacity};
            default:  c = '{8'(lv), 8'(lt), 8'(lp), hue_opacity};
          endcase
        end
        MODE_VEL: c = '{vel_level(vx), vel_level(vy), 8'hFF, 8'hFF};
        default:  c = '0;  // unused mode gives transparent black
      endcase
      return c;
    endfunction

    function void note_cell(logic [23:0] dens, logic signed [17:0] vx,
                            logic signed [17:0] vy);
      pending_colors.push_back(colorize(dens, vx, vy));
    endfunction

    function void check_color(rgba_t got);
      rgba_t want;
      string names[4];
      names = '{"red", "green", "blue", "alpha"};
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected color transfer, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (want[31 - 8 * i -: 8] !== got[31 - 8 * i -: 8]) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, names[i],
                   want[31 - 8 * i -: 8], got[31 - 8 * i -: 8]);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [23:0]        density;
  logic signed [17:0] vel_x;
  logic signed [17:0] vel_y;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;

  color_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;

  field_cell_colorizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .density   (density),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: out_ready changes at the falling edge, stalling at random.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every color transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_color(rgba_t'({red, green, blue, alpha}));
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [17:0] random_vel();
    logic signed [17:0] v;
    if ($urandom_range(0, 1) == 0) v = 18'($urandom());
    else v = 18'(int'($urandom_range(0, 8000)) - 4000);
    return v;
  endfunction

  // Register write: setup cycle, then access cycle; called at a falling edge.
  // Bits above bit 8 carry noise that the block must ignore.
  task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value | ($urandom() << 9);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.load_reg(idx, pwdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wait until every predicted color has come out.
  task automatic wait_drained();
    while (sb.pending_colors.size() != 0) @(negedge clk);
  endtask

  // Reprogram all registers with the pipeline empty and no cell offered.
  task automatic set_regs(input color_mode_t mode, input int sat, input int val,
                          input int opacity);
    in_valid = 1'b0;
    wait_drained();
    apb_write(REG_COLOR_MODE, 32'(mode));
    apb_write(REG_SATURATION, 32'(sat));
    apb_write(REG_VALUE_LEVEL, 32'(val));
    apb_write(REG_HUE_ALPHA, 32'(opacity));
  endtask

  // One cell transfer, with a random number of idle cycles in front of it.
  task automatic send_cell(input logic [23:0] dens, input logic signed [17:0] vx,
                           input logic signed [17:0] vy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    density  = dens;
    vel_x    = vx;
    vel_y    = vy;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(dens, vx, vy);
    @(negedge clk);
  endtask

  function automatic int pick_level();
    int lvl;
    case ($urandom_range(0, 4))
      0:       lvl = 0;
      1:       lvl = 256;
      2:       lvl = 511;
      default: lvl = $urandom_range(0, 511);
    endcase
    return lvl;
  endfunction

  task automatic send_random_cell();
    logic [23:0] dens;
    case ($urandom_range(0, 2))
      0:       dens = 24'($urandom());
      1:       dens = 24'($urandom_range(0, 30000));
      default: dens = {16'($urandom_range(0, 719)), 8'($urandom())};
    endcase
    send_cell(dens, random_vel(), random_vel());
  endtask

  // Main sequence: reset, directed cells, then random segments.
  initial begin
    int phase;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    density  = '0;
    vel_x    = '0;
    vel_y    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // White mode out of reset: alpha rounding, saturation and full scale.
    send_cell(24'd0, random_vel(), random_vel());
    send_cell(24'd50, random_vel(), random_vel());
    send_cell(24'd51, random_vel(), random_vel());
    send_cell(24'd25650, random_vel(), random_vel());
    send_cell(24'd25651, random_vel(), random_vel());
    send_cell(24'hFFFFFF, random_vel(), random_vel());

    // Hue mode at full scale: every sector edge and the wrap at 360.
    set_regs(MODE_HUE, 256, 256, 255);
    send_cell({16'd0, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd59, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd60, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd120, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd180, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd240, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd300, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd359, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd360, 8'($urandom())}, random_vel(), random_vel());
    send_cell(24'hFFFFFF, random_vel(), random_vel());

    // Saturation and value above one, then both at zero.
    set_regs(MODE_HUE, 511, 300, 0);
    send_cell({16'd200, 8'($urandom())}, random_vel(), random_vel());
    send_cell({16'd45, 8'($urandom())}, random_vel(), random_vel());
    set_regs(MODE_HUE, 0, 0, 128);
    send_cell({16'd100, 8'($urandom())}, random_vel(), random_vel());

    // Velocity map: range extremes and both sides of the clamp points.
    set_regs(MODE_VEL, 256, 256, 255);
    send_cell(24'($urandom()), -18'sd131072, 18'sd131071);
    send_cell(24'($urandom()), -18'sd3277, 18'sd3277);
    send_cell(24'($urandom()), -18'sd3276, 18'sd3276);
    send_cell(24'($urandom()), 18'sd0, 18'sd1);

    // Unused mode three.
    set_regs(MODE_NONE, 256, 256, 255);
    send_cell(24'($urandom()), random_vel(), random_vel());

    // Random segments, each with its own register setting; each group of three shares an idle pattern.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      set_regs(color_mode_t'(seg % 4), pick_level(), pick_level(),
               ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                           : $urandom_range(0, 255));
      phase = seg / 3;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int n = 0; n < CELLS_PER_SEGMENT; n++) send_random_cell();
    end
    in_valid = 1'b0;

    // Drain, then give a stray result time to show up.
    wait_drained();
    repeat (NumStages + 4) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
